FILE: src/rdss_pkg.sv
// Shared types, constants and the glyph table for the radix digit seven-segment scanner.
// Used by every module of the block; depends on nothing.
package rdss_pkg;

  localparam int VALUE_W      = 16;
  localparam int RADIX_W      = 5;
  localparam int CODE_W       = 5;
  localparam int REM_W        = 4;
  localparam int POS_W        = 3;
  localparam int SEL_W        = 4;
  localparam int SEG_W        = 8;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 16;
  localparam int DIGIT_COUNT_DEF = 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CODE_W-1:0]  BLANK_CODE = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_MIN  = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 5'd16;

  // Request to the shared divider
  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [RADIX_W-1:0] divisor;
  } div_req_t;

  // Status back from the divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Digit store and scan control
  typedef struct packed {
    logic              clr_upper;
    logic              wr_en;
    logic [POS_W-1:0]  wr_pos;
    logic [CODE_W-1:0] wr_code;
    logic              tick;
  } disp_ctl_t;

  // Segments a..g in bits 0..6, dot in bit 7; active high here
  function automatic logic [SEG_W-1:0] glyph_f(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] g;
    case (code)
      5'd0:    g = 8'h3F;
      5'd1:    g = 8'h06;
      5'd2:    g = 8'h5B;
      5'd3:    g = 8'h4F;
      5'd4:    g = 8'h66;
      5'd5:    g = 8'h6D;
      5'd6:    g = 8'h7D;
      5'd7:    g = 8'h07;
      5'd8:    g = 8'h7F;
      5'd9:    g = 8'h6F;
      5'd10:   g = 8'h77;
      5'd11:   g = 8'h7C;
      5'd12:   g = 8'h58;
      5'd13:   g = 8'h5E;
      5'd14:   g = 8'h79;
      5'd15:   g = 8'h71;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

FILE: src/radix_digit_seven_segment_scanner_top.sv
// Top level of the radix digit seven-segment scanner: load sequencer around the
// shared divider and the display store. Depends on rdss_pkg, rdss_div, rdss_disp.

// A tick transaction (in_tuser = 1) is taken and its select and segment pattern
// is registered for out_tdata; two results may wait before in_tready drops. A
// load transaction (in_tuser = 0) splits the number into digits with one shared
// bit-serial divider at one quotient bit per cycle, one digit after the other,
// for as many digits as the number has, up to DIGIT_COUNT; in_tready stays low
// during a load. Radix values below 2 act as 2 and above 16 act as 16; upper
// positions above the leading digit are blank and position zero shows a digit
// after any load.
module radix_digit_seven_segment_scanner_top #(
  parameter int DIGIT_COUNT = rdss_pkg::DIGIT_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [15:0] number_value, [20:16] number_radix, [23:21] zero
  input  logic [rdss_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] operation
  input  logic [0:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [3:0] digit_select_n, [11:4] segments_n, [15:12] zero
  output logic [rdss_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import rdss_pkg::*;

  localparam int PW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DIV  = 1'b1;

  logic               state_r, state_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [RADIX_W-1:0] radix_r, radix_nxt;
  logic               accept;
  logic [VALUE_W-1:0] in_value;
  logic [RADIX_W-1:0] in_radix;
  logic [RADIX_W-1:0] radix_cl;
  logic               disp_ready;
  logic               last_digit;
  div_req_t           div_req;
  div_stat_t          div_stat;
  logic [VALUE_W-1:0] div_quo;
  logic [REM_W-1:0]   div_rem;
  disp_ctl_t          disp_ctl;

  assign in_value = in_tdata[VALUE_W-1:0];
  assign in_radix = in_tdata[VALUE_W +: RADIX_W];

  always_comb begin
    radix_cl = in_radix;
    if (in_radix < RADIX_MIN) begin
      radix_cl = RADIX_MIN;
    end else if (in_radix > RADIX_MAX) begin
      radix_cl = RADIX_MAX;
    end
  end

  assign in_tready  = (state_r == S_IDLE) && disp_ready;
  assign accept     = in_tvalid && in_tready;
  assign last_digit = (div_quo == '0) || (pos_r == PW'(DIGIT_COUNT - 1));

  always_comb begin
    state_nxt        = state_r;
    pos_nxt          = pos_r;
    radix_nxt        = radix_r;
    div_req.start    = 1'b0;
    div_req.dividend = div_quo;
    div_req.divisor  = radix_r;
    disp_ctl.clr_upper = 1'b0;
    disp_ctl.wr_en     = 1'b0;
    disp_ctl.wr_pos    = POS_W'(pos_r);
    disp_ctl.wr_code   = CODE_W'(div_rem);
    disp_ctl.tick      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_tuser[0] == OP_TICK) begin
            disp_ctl.tick = 1'b1;
          end else begin
            disp_ctl.clr_upper = 1'b1;
            div_req.start      = 1'b1;
            div_req.dividend   = in_value;
            div_req.divisor    = radix_cl;
            radix_nxt          = radix_cl;
            pos_nxt            = '0;
            state_nxt          = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          disp_ctl.wr_en = 1'b1;
          if (last_digit) begin
            state_nxt = S_IDLE;
          end else begin
            // continue on the quotient with the radix held from this load
            div_req.start = 1'b1;
            pos_nxt       = pos_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      radix_r <= RADIX_MIN;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      radix_r <= radix_nxt;
    end
  end

  rdss_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  rdss_disp #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_disp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (disp_ctl),
    .ready      (disp_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: src/rdss_div.sv
// Shared bit-serial restoring divider: 16-bit dividend by a radix of 2..16.
// One quotient bit per cycle. Depends on rdss_pkg.
module rdss_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rdss_pkg::div_req_t                  req,
  output rdss_pkg::div_stat_t                 stat,
  output logic [rdss_pkg::VALUE_W-1:0]        quotient,
  output logic [rdss_pkg::REM_W-1:0]          remainder
);
  import rdss_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W);

  logic [VALUE_W-1:0] quo_r, quo_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [RADIX_W-1:0] dvs_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [REM_W:0]     trial;
  logic               fits;

  assign trial = {rem_r, quo_r[VALUE_W-1]};
  assign fits  = (trial >= dvs_r);

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the difference fits REM_W bits
      rem_nxt = fits ? REM_W'(trial - dvs_r) : trial[REM_W-1:0];
      quo_nxt = {quo_r[VALUE_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(VALUE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: src/rdss_disp.sv
// Digit code store, scan position and glyph lookup with a two-slot output buffer.
// Depends on rdss_pkg.
module rdss_disp #(
  parameter int DIGIT_COUNT = rdss_pkg::DIGIT_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rdss_pkg::disp_ctl_t                 ctl,
  output logic                                ready,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rdss_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import rdss_pkg::*;

  localparam int PW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic [CODE_W-1:0]      digit_r [DIGIT_COUNT];
  logic [PW-1:0]          scan_r, scan_nxt;
  logic [CODE_W-1:0]      cur_code;
  logic [SEL_W-1:0]       sel_n;
  logic [SEG_W-1:0]       seg_n;
  logic [OUT_TDATA_W-1:0] res;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] skid_data_r;
  logic                   out_valid_r;
  logic                   skid_valid_r;
  logic                   take;

  always_comb begin
    cur_code = BLANK_CODE;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (scan_r == PW'(i)) begin
        cur_code = digit_r[i];
      end
    end
  end

  // positions without a select line leave all selects high
  always_comb begin
    for (int i = 0; i < SEL_W; i++) begin
      sel_n[i] = (32'(scan_r) != 32'(i));
    end
  end

  assign seg_n = ~glyph_f(cur_code);
  assign res   = {(OUT_TDATA_W - SEL_W - SEG_W)'(0), seg_n, sel_n};

  assign scan_nxt = (scan_r == PW'(DIGIT_COUNT - 1)) ? '0 : scan_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit_r[i] <= BLANK_CODE;
      end
    end else begin
      if (ctl.tick) begin
        scan_r <= scan_nxt;
      end
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        if (ctl.clr_upper && i != 0) begin
          digit_r[i] <= BLANK_CODE;
        end else if (ctl.wr_en && ctl.wr_pos == POS_W'(i)) begin
          digit_r[i] <= ctl.wr_code;
        end
      end
    end
  end

  assign take = out_valid_r && out_tready;

  // output register plus skid slot; a tick is taken only while the skid is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (ctl.tick) begin
      if (out_valid_r && !take) begin
        skid_valid_r <= 1'b1;
      end
      out_valid_r <= 1'b1;
    end else if (take) begin
      out_valid_r  <= skid_valid_r;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tick) begin
      if (!out_valid_r || take) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end else if (take && skid_valid_r) begin
      out_data_r <= skid_data_r;
    end
  end

  assign ready      = !skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: src/rdss_checker.sv
// Port-level assertions for the radix digit seven-segment scanner and their bind.
// Depends on rdss_pkg and the top level's port list.
module rdss_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [rdss_pkg::IN_TDATA_W-1:0]     in_tdata,
  input logic [0:0]                          in_tuser,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [rdss_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import rdss_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

  // dot stays off and padding stays zero
  a_out_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[SEL_W + SEG_W - 1] && (out_tdata[OUT_TDATA_W-1:SEL_W+SEG_W] == '0))
    else $error("dot lit or padding set");

  // at most one digit selected
  a_one_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $countones(out_tdata[SEL_W-1:0]) >= SEL_W - 1)
    else $error("more than one digit selected");

  // a load occupies the divider, so nothing is taken in the next cycle
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == OP_LOAD) |=> !in_tready)
    else $error("transaction taken during digit split");

endmodule

bind radix_digit_seven_segment_scanner_top rdss_checker u_rdss_checker (.*);

FILE: tb/sv/tb_radix_digit_seven_segment_scanner_top.sv
// Self-checking testbench for radix_digit_seven_segment_scanner_top: directed table, then
// random loads and scan ticks under four idling phases, checked against an in-bench predictor.
// Depends on rdss_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_radix_digit_seven_segment_scanner_top;
  import rdss_pkg::*;

  localparam int NUM_DIGITS  = DIGIT_COUNT_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 100;

  // Active-high segment patterns for codes 0..15, then blank
  localparam logic [7:0] GLYPH_LUT [17] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71,
    8'h00
  };

  typedef struct packed {
    logic [3:0] sel_n;
    logic [7:0] seg_n;
  } scan_out_t;

  typedef struct packed {
    logic       op;
    logic [15:0] value;
    logic [4:0] radix;
    logic       typed;
    logic [3:0] sel_n;
    logic [7:0] seg_n;
  } stim_row_t;

  // Rows with typed = 1 carry the expected output; the rest use the predictor
  localparam int DIRECTED_ROWS = 24;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{OP_TICK, 16'd0,     5'd0,  1'b1, 4'hE, 8'hFF},
    '{OP_TICK, 16'd0,     5'd0,  1'b1, 4'hD, 8'hFF},
    '{OP_TICK, 16'd0,     5'd0,  1'b1, 4'hB, 8'hFF},
    '{OP_TICK, 16'd0,     5'd0,  1'b1, 4'h7, 8'hFF},
    '{OP_LOAD, 16'd0,     5'd10, 1'b0, 4'h0, 8'h00},
    '{OP_TICK, 16'd0,     5'd0,  1'b1, 4'hE, 8'hC0},
    '{OP_LOAD, 16'hFFFF,  5'd16, 1'b0, 4'h0, 8'h00},
    '{OP_TICK, 16'hFFFF,  5'd31, 1'b0, 4'h0, 8'h00},
    '{OP_TICK, 16'd0,     5'd0,  1'b0, 4'h0, 8'h00},
    '{OP_TICK, 16'd0,     5'd0,  1'b0, 4'h0, 8'h00},
    '{OP_TICK, 16'd0,     5'd0,  1'b0, 4'h0, 8'h00},
    '{OP_LOAD, 16'hFFFF,  5'd2,  1'b0, 4'h0, 8'h00},
    '{OP_TICK, 16'd0,     5'd0,  1'b0, 4'h0, 8'h00},
    '{OP_LOAD, 16'd5,     5'd0,  1'b0, 4'h0, 8'h00},
    '{OP_TICK, 16'd0,     5'd0,  1'b0, 4'h0, 8'h00},
    '{OP_LOAD, 16'd5,     5'd1,  1'b0, 4'h0, 8'h00},
    '{OP_TICK, 16'd0,     5'd0,  1'b0, 4'h0, 8'h00},
    '{OP_LOAD, 16'd300,   5'd31, 1'b0, 4'h0, 8'h00},
    '{OP_TICK, 16'd0,     5'd0,  1'b0, 4'h0, 8'h00},
    '{OP_TICK, 16'd0,     5'd0,  1'b0, 4'h0, 8'h00},
    '{OP_LOAD, 16'd4660,  5'd17, 1'b0, 4'h0, 8'h00},
    '{OP_TICK, 16'd0,     5'd0,  1'b0, 4'h0, 8'h00},
    '{OP_TICK, 16'd0,     5'd0,  1'b0, 4'h0, 8'h00},
    '{OP_LOAD, 16'd12345, 5'd10, 1'b0, 4'h0, 8'h00}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  // Predictor state
  logic [4:0] digit_store [NUM_DIGITS];
  int         scan_pos;

  scan_out_t  expected_scans [$];
  int         mismatch_count;
  int         loads_sent;
  int         scans_checked;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         hold_cycles;
  int         cycle_count;

  radix_digit_seven_segment_scanner_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Digit split on load, glyph lookup and scan advance on tick
  function automatic bit display_step(input logic op, input logic [15:0] value,
                                      input logic [4:0] radix, output scan_out_t res);
    int unsigned v;
    int unsigned r;
    int          p;
    v   = value;
    r   = radix;
    res = '0;
    if (op == OP_LOAD) begin
      if (r < 2) r = 2;
      if (r > 16) r = 16;
      for (p = 1; p < NUM_DIGITS; p++) digit_store[p] = 5'd16;
      p = 0;
      do begin
        digit_store[p] = 5'(v % r);
        v = v / r;
        p++;
      end while (v != 0 && p < NUM_DIGITS);
      return 1'b0;
    end
    res.sel_n = ~(4'b0001 << scan_pos);
    res.seg_n = ~GLYPH_LUT[digit_store[scan_pos]];
    scan_pos  = (scan_pos + 1) % NUM_DIGITS;
    return 1'b1;
  endfunction

  task automatic send_item(input logic op, input logic [15:0] value, input logic [4:0] radix,
                           input logic typed, input scan_out_t typed_res);
    scan_out_t res;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, radix, value};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    if (display_step(op, value, radix, res)) begin
      expected_scans.push_back(typed ? typed_res : res);
    end else begin
      loads_sent++;
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when requested
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    scan_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_scans.size() == 0) begin
        $display("%0t: unexpected result sel_n=%h seg_n=%h", $time,
                 out_tdata[3:0], out_tdata[11:4]);
        mismatch_count++;
      end else begin
        want = expected_scans.pop_front();
        scans_checked++;
        if (out_tdata[3:0] !== want.sel_n) begin
          $display("%0t: digit_select_n expected %h actual %h", $time,
                   want.sel_n, out_tdata[3:0]);
          mismatch_count++;
        end
        if (out_tdata[11:4] !== want.seg_n) begin
          $display("%0t: segments_n expected %h actual %h", $time,
                   want.seg_n, out_tdata[11:4]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                 expected_scans.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int        phase;
    int        n;
    int        w;
    logic      op;
    logic [15:0] value;
    logic [4:0] radix;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    mismatch_count = 0;
    loads_sent     = 0;
    scans_checked  = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    for (n = 0; n < NUM_DIGITS; n++) digit_store[n] = 5'd16;
    scan_pos = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < DIRECTED_ROWS; n++) begin
      send_item(DIRECTED[n].op, DIRECTED[n].value, DIRECTED[n].radix, DIRECTED[n].typed,
                '{DIRECTED[n].sel_n, DIRECTED[n].seg_n});
    end

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      if (phase == 0) begin
        // Hold the output long enough that the block backs up into its input
        hold_cycles = 300;
        for (n = 0; n < 20; n++) send_item(OP_TICK, 16'd0, 5'd0, 1'b0, '0);
      end
      for (n = 0; n < 95; n++) begin
        op    = ($urandom_range(0, 99) < 75) ? OP_TICK : OP_LOAD;
        w     = $urandom_range(0, 16);
        value = 16'($urandom) & 16'((32'd1 << w) - 1);
        radix = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(2, 16));
        send_item(op, value, radix, 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;

    while (expected_scans.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Checked %0d scan outputs and %0d number loads across four idling phases,",
             scans_checked, loads_sent);
    $display("with one long output hold-off; %0d mismatches", mismatch_count);
    if (mismatch_count == 0 && expected_scans.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
